@@ rtl/mndt_pkg.sv @@
// Shared types and constants for the MIDI note duration tracker.
// No dependencies; the top and mndt_track import this package.
`timescale 1ns / 1ps

package mndt_pkg;

  localparam int NOTE_COUNT     = 128;
  localparam int NOTE_BITS      = 7;
  localparam int TIME_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 16;

  // operation codes carried on in_tuser
  localparam logic [1:0] OP_KEY   = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  typedef struct packed {
    logic [1:0]           op;
    logic [NOTE_BITS-1:0] note;
    logic [6:0]           velocity;
    logic                 note_on;
    logic [31:0]          timestamp;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] rel_time;
    logic [31:0] duration;
    logic        duration_valid;
    logic [15:0] note_total;
    logic [31:0] capture_length;
    logic        capturing;
  } result_t;

endpackage

@@ rtl/midi_note_duration_tracker.sv @@
// MIDI note duration tracker: words pass the s1 and output registers, one word
// per cycle unless out_tready stalls, with one note-table read and at most one
// write per word and the write of the word ahead bypassed into the next word on
// a note match. Synchronous active-low reset clears capture state, counters and
// the 128 note-active flags at once; note start times are not cleared and are
// used only for active notes. Depends on mndt_pkg, mndt_ram and mndt_track.
`timescale 1ns / 1ps

module midi_note_duration_tracker
  import mndt_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // note[6:0], velocity[13:7], note_on[14], timestamp[46:15], zero pad [47]
  input  logic [47:0]  in_tdata,
  // op[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // rel_time[31:0], duration[63:32], note_total[79:64],
  // capture_length[111:80], capturing[112], zero pad [119:113]
  output logic [119:0] out_tdata,
  // accepted[0], duration_valid[1]
  output logic [1:0]   out_tuser
);

  item_t                s1_item_r;
  logic                 s1_valid_r;
  logic                 s1_fwd_r;
  logic [TIME_BITS-1:0] s1_fwd_data_r;
  logic                 out_valid_r;
  result_t              out_res_r;

  logic                 s1_fire;
  logic                 in_acc;
  item_t                in_item;
  result_t              res;
  logic                 wr_en;
  logic [NOTE_BITS-1:0] wr_addr;
  logic [TIME_BITS-1:0] wr_data;
  logic [TIME_BITS-1:0] rd_data;
  logic [TIME_BITS-1:0] stored_time;

  assign in_item.op        = in_tuser;
  assign in_item.note      = in_tdata[6:0];
  assign in_item.velocity  = in_tdata[13:7];
  assign in_item.note_on   = in_tdata[14];
  assign in_item.timestamp = in_tdata[46:15];

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_acc    = in_tvalid && in_tready;

  mndt_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (NOTE_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (in_item.note),
    .rd_data (rd_data)
  );

  // the RAM returns old data when read and written at the same edge
  assign stored_time = s1_fwd_r ? s1_fwd_data_r : rd_data;

  mndt_track #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (s1_fire),
    .item        (s1_item_r),
    .stored_time (stored_time),
    .res         (res),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r     <= in_item;
      s1_fwd_r      <= wr_en && (wr_addr == in_item.note);
      s1_fwd_data_r <= wr_data;
    end
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.capturing, out_res_r.capture_length,
                       out_res_r.note_total, out_res_r.duration, out_res_r.rel_time};
  assign out_tuser  = {out_res_r.duration_valid, out_res_r.accepted};

  a_dvalid_needs_accept : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("duration_valid without accepted");

  a_idle_fields_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata[63:0] == 64'd0))
    else $error("rel_time or duration nonzero on a non-recorded word");

  a_start_clears : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_item_r.op == OP_START) |=>
      out_tvalid && out_tdata[112] && (out_tdata[111:64] == 48'd0))
    else $error("start did not clear counters or enable capture");

endmodule

@@ rtl/mndt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mndt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/mndt_track.sv @@
// Capture state, per-note active flags and result computation for one word.
// Depends on mndt_pkg; the note start times live in an external mndt_ram.
`timescale 1ns / 1ps

module mndt_track
  import mndt_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  item_t                item,
  input  logic [TIME_BITS-1:0] stored_time,
  output result_t              res,
  output logic                 wr_en,
  output logic [NOTE_BITS-1:0] wr_addr,
  output logic [TIME_BITS-1:0] wr_data
);

  logic [NOTE_COUNT-1:0] active_r, active_nxt;
  logic [TIME_BITS-1:0]  start_r, start_nxt;
  logic                  have_r, have_nxt;
  logic                  cap_r, cap_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [TIME_BITS-1:0]  last_r, last_nxt;

  logic [TIME_BITS-1:0]  ts;
  logic [TIME_BITS-1:0]  rel;
  logic [TIME_BITS-1:0]  dur;
  logic                  ev;
  logic                  on_ev;
  logic                  hit;
  logic                  close;
  logic [31:0]           cnt_ext;

  assign ts    = TIME_BITS'(item.timestamp);
  // first event of a capture is its own origin
  assign rel   = have_r ? (ts - start_r) : '0;
  assign dur   = rel - stored_time;
  assign ev    = (item.op == OP_KEY) && cap_r;
  assign on_ev = item.note_on && (item.velocity != 7'd0);
  assign hit   = active_r[item.note];
  assign close = ev && !on_ev && hit;

  always_comb begin
    active_nxt = active_r;
    start_nxt  = start_r;
    have_nxt   = have_r;
    cap_nxt    = cap_r;
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    case (item.op)
      OP_START: begin
        active_nxt = '0;
        start_nxt  = '0;
        have_nxt   = 1'b0;
        cnt_nxt    = '0;
        last_nxt   = '0;
        cap_nxt    = 1'b1;
      end
      OP_STOP: begin
        cap_nxt = 1'b0;
      end
      OP_KEY: begin
        if (cap_r) begin
          if (!have_r) begin
            start_nxt = ts;
            have_nxt  = 1'b1;
          end
          last_nxt = rel;
          if (on_ev) begin
            active_nxt[item.note] = 1'b1;
            if (cnt_r != {COUNT_BITS{1'b1}}) begin
              cnt_nxt = cnt_r + COUNT_BITS'(1);
            end
          end else if (hit) begin
            active_nxt[item.note] = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign cnt_ext = 32'(cnt_nxt);

  always_comb begin
    res.accepted       = ev;
    res.rel_time       = ev ? 32'(rel) : 32'd0;
    res.duration       = close ? 32'(dur) : 32'd0;
    res.duration_valid = close;
    res.note_total     = (cnt_ext > 32'h0000_FFFF) ? 16'hFFFF : cnt_ext[15:0];
    res.capture_length = 32'(last_nxt);
    res.capturing      = cap_nxt;
  end

  assign wr_en   = fire && ev && on_ev;
  assign wr_addr = item.note;
  assign wr_data = rel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      start_r  <= '0;
      have_r   <= 1'b0;
      cap_r    <= 1'b0;
      cnt_r    <= '0;
      last_r   <= '0;
    end else if (fire) begin
      active_r <= active_nxt;
      start_r  <= start_nxt;
      have_r   <= have_nxt;
      cap_r    <= cap_nxt;
      cnt_r    <= cnt_nxt;
      last_r   <= last_nxt;
    end
  end

endmodule
